// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the distance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, cond, expr)
`endif
`endif

// ----- hdl/adef_pkg.sv -----
// Package with the fixed field widths and limits of the distance block.
`timescale 1ns / 1ps
package adef_pkg;
   localparam int unsigned DIST_WIDTH = 16;
   localparam int unsigned THR_WIDTH = 16;
   localparam logic [DIST_WIDTH-1:0] DIST_MAX = 16'hFFFF;
endpackage

// ----- hdl/approx_distance_exact_fallback.sv -----
// Top level of the pipelined octagonal distance estimator with exact fallback.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block takes one beat in every clock cycle and returns its result, in the
// same order, from the output register at the end of the pipeline on a
// one-cycle strobe; the receiver cannot hold results off and needs none.
// The pipeline consists of the integer square root, which produces one root bit
// per pipeline stage over COORD_WIDTH + 1 stages, plus four stages for the
// magnitudes, the squares, the sum and the output register.
// Busy is high only while reset is asserted.
module approx_distance_exact_fallback #(
   parameter int unsigned COORD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_offset_x,
   input  logic signed [COORD_WIDTH-1:0]        req_offset_y,
   input  logic [adef_pkg::THR_WIDTH-1:0]       req_exact_below,
   output logic                                 strobe,
   output logic [adef_pkg::DIST_WIDTH-1:0]      rsp_distance,
   output logic                                 rsp_exact_used
);
   localparam int unsigned MW = COORD_WIDTH;
   localparam int unsigned SQW = 2 * MW;
   localparam int unsigned SUMW = 2 * MW + 1;
   localparam int unsigned RW = MW + 1;
   localparam int unsigned RADW = 2 * RW;
   localparam int unsigned REMW = RW + 2;
   localparam int unsigned EW = MW + 2;
   localparam int unsigned RESW = (EW > adef_pkg::DIST_WIDTH) ? EW : adef_pkg::DIST_WIDTH + 1;
   localparam int unsigned LAT = RW + 4;
   localparam int unsigned TW = adef_pkg::THR_WIDTH;

   logic accept;
   logic zero_thr_beat;
   logic exact_beat;

   logic          s1_vld_ff;
   logic [MW-1:0] mag_x_ff, mag_x_in;
   logic [MW-1:0] mag_y_ff, mag_y_in;
   logic [TW-1:0] s1_thr_ff;

   logic           s2_vld_ff;
   logic [SQW-1:0] sq_x_ff, sq_x_in;
   logic [SQW-1:0] sq_y_ff, sq_y_in;
   logic [EW-1:0]  est0_ff, est0_in;
   logic [TW-1:0]  s2_thr_ff;
   logic [MW-1:0]  big, small_mag;
   logic [MW:0]    two_small, diff;
   logic [MW+2:0]  diff3;
   logic [MW-2:0]  corr;

   logic            vld_ff  [RW+1];
   logic [RADW-1:0] rad_ff  [RW+1];
   logic [REMW-1:0] rem_ff  [RW+1];
   logic [RW-1:0]   root_ff [RW+1];
   logic [EW-1:0]   est_ff  [RW+1];
   logic [TW-1:0]   thr_ff  [RW+1];
   logic [RADW-1:0] rad_in  [RW+1];
   logic [REMW-1:0] rem_in  [RW+1];
   logic [RW-1:0]   root_in [RW+1];
   logic [EW-1:0]   est_in;

   logic                           strobe_ff;
   logic [adef_pkg::DIST_WIDTH-1:0] dist_ff, dist_in;
   logic                           exact_ff, exact_in;
   logic [RESW-1:0]                res_wide;

   assign busy = reset;
   assign accept = start && !busy;

   // Stage 1: magnitudes of the two offsets.
   always_comb begin
      mag_x_in = req_offset_x[MW-1] ? (~req_offset_x[MW-1:0] + MW'(1)) : req_offset_x[MW-1:0];
      mag_y_in = req_offset_y[MW-1] ? (~req_offset_y[MW-1:0] + MW'(1)) : req_offset_y[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      mag_x_ff  <= mag_x_in;
      mag_y_ff  <= mag_y_in;
      s1_thr_ff <= req_exact_below;
   end

   // Stage 2: squares and the raw octagonal estimate.
   always_comb begin
      sq_x_in = SQW'(mag_x_ff) * SQW'(mag_x_ff);
      sq_y_in = SQW'(mag_y_ff) * SQW'(mag_y_ff);
      if (mag_x_ff < mag_y_ff) begin
         big       = mag_y_ff;
         small_mag = mag_x_ff;
      end else begin
         big       = mag_x_ff;
         small_mag = mag_y_ff;
      end
      two_small = {small_mag, 1'b0};
      diff      = two_small - {1'b0, big};
      diff3     = {1'b0, diff, 1'b0} + {2'b00, diff};
      corr      = (two_small > {1'b0, big}) ? diff3[MW+2:4] : '0;
      est0_in   = EW'(big) + EW'(small_mag[MW-1:2]) + EW'(corr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      sq_x_ff   <= sq_x_in;
      sq_y_ff   <= sq_y_in;
      est0_ff   <= est0_in;
      s2_thr_ff <= s1_thr_ff;
   end

   // Stage 3: sum of squares and the scaled estimate.
   always_comb begin
      rad_in[0]  = RADW'(SUMW'(sq_x_ff) + SUMW'(sq_y_ff));
      rem_in[0]  = '0;
      root_in[0] = '0;
      est_in     = est0_ff - (est0_ff >> 6);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= s2_vld_ff;
      end
      rad_ff[0]  <= rad_in[0];
      rem_ff[0]  <= rem_in[0];
      root_ff[0] <= root_in[0];
      est_ff[0]  <= est_in;
      thr_ff[0]  <= s2_thr_ff;
   end

   // Square root stages, one root bit per stage.
   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      logic [REMW-1:0] cur;
      logic [REMW-1:0] trial;
      logic            take;

      always_comb begin
         cur   = {rem_ff[k][REMW-3:0], rad_ff[k][RADW-1 -: 2]};
         trial = {root_ff[k], 2'b01};
         take  = (cur >= trial);
         rad_in[k+1]  = {rad_ff[k][RADW-3:0], 2'b00};
         rem_in[k+1]  = take ? (cur - trial) : cur;
         root_in[k+1] = {root_ff[k][RW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rad_ff[k+1]  <= rad_in[k+1];
         rem_ff[k+1]  <= rem_in[k+1];
         root_ff[k+1] <= root_in[k+1];
         est_ff[k+1]  <= est_ff[k];
         thr_ff[k+1]  <= thr_ff[k];
      end
   end

   // Output stage: pick the path and saturate.
   always_comb begin
      exact_in = (RESW'(est_ff[RW]) < RESW'(thr_ff[RW]));
      res_wide = exact_in ? RESW'(root_ff[RW]) : RESW'(est_ff[RW]);
      dist_in  = (res_wide > RESW'(adef_pkg::DIST_MAX)) ?
                 adef_pkg::DIST_MAX : res_wide[adef_pkg::DIST_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[RW];
      end
      dist_ff  <= dist_in;
      exact_ff <= exact_in;
   end

   assign strobe         = strobe_ff;
   assign rsp_distance   = dist_ff;
   assign rsp_exact_used = exact_ff;

   assign zero_thr_beat = accept && (req_exact_below == '0);
   assign exact_beat    = strobe && rsp_exact_used;

   `ASSERT_ALWAYS(a_strobe_latency, clock, reset, strobe == $past(accept, LAT))
   `ASSERT_IMPLY(a_zero_thr_approx, clock, reset, zero_thr_beat, ##LAT (strobe && !rsp_exact_used))
   `ASSERT_IMPLY(a_exact_in_range, clock, reset, exact_beat, rsp_distance <= $past(root_ff[RW]))
endmodule
